FILE: rtl/core/circuit_breaker_table_assert.svh
// ----------------------------------------------------------------------------
// circuit_breaker_table_assert.svh
// Assertion macros used by the circuit breaker table RTL.
// ----------------------------------------------------------------------------
`ifndef CIRCUIT_BREAKER_TABLE_ASSERT_SVH
`define CIRCUIT_BREAKER_TABLE_ASSERT_SVH

// Same-cycle implication, checked on i_clk outside reset.
`define CBT_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on i_clk outside reset.
`define CBT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/cbt_pkg.sv
// ----------------------------------------------------------------------------
// cbt_pkg
// Shared types and constants of the circuit breaker table.
// ----------------------------------------------------------------------------
package cbt_pkg;

    // Default table depth
    localparam int unsigned ENTRIES_DEF = 32;

    // Register map (register index, byte address = 4 * index)
    localparam logic REG_THRESHOLD = 1'b0;

    localparam logic [15:0] THRESHOLD_RST = 16'd5;
    localparam logic [15:0] COUNT_MAX     = 16'hFFFF;

    // Request opcodes; other codes behave like a query
    typedef enum logic [2:0] {
        OP_ERROR     = 3'd0,
        OP_SUCCESS   = 3'd1,
        OP_RESET_ONE = 3'd2,
        OP_QUERY     = 3'd3,
        OP_RESET_ALL = 3'd4
    } t_op;

    // Result status codes
    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_UNTRACKED = 2'd1,
        STS_FULL      = 2'd2
    } t_status;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_DONE
    } t_state;

    // One breaker entry as stored in the table
    typedef struct packed {
        logic [31:0] key;
        logic [15:0] errors;
        logic        open;
    } t_entry;

endpackage

FILE: rtl/core/cbt_store.sv
// ----------------------------------------------------------------------------
// cbt_store
// Breaker entry memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module cbt_store #(
    parameter int unsigned ENTRIES = 32,
    parameter int unsigned IDX_W   = 5
) (
    input  logic                  i_clk,
    input  logic                  i_rd_en,
    input  logic [IDX_W-1:0]      i_rd_addr,
    output cbt_pkg::t_entry       o_rd_data,
    input  logic                  i_wr_en,
    input  logic [IDX_W-1:0]      i_wr_addr,
    input  cbt_pkg::t_entry       i_wr_data
);
    import cbt_pkg::*;

    t_entry r_mem [ENTRIES];
    t_entry r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, data registered
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/core/circuit_breaker_table.sv
// ----------------------------------------------------------------------------
// circuit_breaker_table
// Table of circuit breakers keyed by a 32-bit id, with error counting.
// ----------------------------------------------------------------------------
// One request is worked on at a time. A request walks the used part of the
// table one entry per cycle through the single read port of the entry
// memory, while a reset-all skips the walk. The next request is taken no
// earlier than the cycle after the result is loaded into the output
// register. The block stalls its input while a request is in work; a
// finished result sits in an output register, so the next request may be
// taken while that result still waits. The error threshold is written at
// byte address 0 of the APB port and reads back there.
// ----------------------------------------------------------------------------
module circuit_breaker_table #(
    parameter int unsigned ENTRIES = cbt_pkg::ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_opcode,
    input  logic [31:0] i_index_id,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic        o_is_open,
    output logic [15:0] o_error_count,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import cbt_pkg::*;

    localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
    localparam logic [CNT_W-1:0] USED_MAX = CNT_W'(ENTRIES);

    t_state            r_state, n_state;
    logic [2:0]        r_op, n_op;
    logic [31:0]       r_key, n_key;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic              r_pend, n_pend;
    logic [CNT_W-1:0]  r_used, n_used;
    logic [IDX_W-1:0]  r_slot, n_slot;
    t_entry            r_ent, n_ent;
    t_status           r_status, n_status;
    logic              r_res_open, n_res_open;
    logic [15:0]       r_res_cnt, n_res_cnt;
    logic [15:0]       r_thr;
    logic              r_out_valid;
    logic [1:0]        r_out_status;
    logic              r_out_open;
    logic [15:0]       r_out_cnt;

    logic              rd_en;
    t_entry            rd_data;
    logic              wr_en;
    t_entry            wr_data;
    logic              hit;
    logic              scan_end;
    logic              ld;
    logic              cfg_wr;
    logic [CNT_W-1:0]  pend_idx;
    logic [15:0]       inc_cnt;

    // Entry memory
    cbt_store #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_idx[IDX_W-1:0]),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_slot),
        .i_wr_data (wr_data)
    );

    // Configuration register
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_THRESHOLD);
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_THRESHOLD) ? {16'd0, r_thr} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THRESHOLD_RST;
        end else if (cfg_wr) begin
            r_thr <= pwdata[15:0];
        end
    end

    // Scan compare: a pending read returns the entry one behind r_idx
    assign hit      = r_pend && (rd_data.key == r_key);
    assign scan_end = (r_idx >= r_used);
    assign pend_idx = r_idx - CNT_W'(1);
    assign inc_cnt  = (r_ent.errors == COUNT_MAX) ? COUNT_MAX : r_ent.errors + 16'd1;

    // Result handoff into the output register
    assign ld      = (r_state == ST_DONE) && (!r_out_valid || !i_stall);
    assign o_stall = (r_state != ST_IDLE);

    // Sequencer: next state and datapath controls
    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_key      = r_key;
        n_idx      = r_idx;
        n_pend     = 1'b0;
        n_used     = r_used;
        n_slot     = r_slot;
        n_ent      = r_ent;
        n_status   = r_status;
        n_res_open = r_res_open;
        n_res_cnt  = r_res_cnt;
        rd_en      = 1'b0;
        wr_en      = 1'b0;
        wr_data    = r_ent;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_op  = i_opcode;
                    n_key = i_index_id;
                    n_idx = '0;
                    if (i_opcode == OP_RESET_ALL) begin
                        n_used     = '0;
                        n_status   = STS_OK;
                        n_res_open = 1'b0;
                        n_res_cnt  = '0;
                        n_state    = ST_DONE;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (hit) begin
                    n_slot  = pend_idx[IDX_W-1:0];
                    n_ent   = rd_data;
                    n_state = ST_UPDATE;
                end else if (!scan_end) begin
                    // issue the next read
                    rd_en  = 1'b1;
                    n_pend = 1'b1;
                    n_idx  = r_idx + CNT_W'(1);
                end else if (r_op == OP_ERROR) begin
                    if (r_used < USED_MAX) begin
                        // append a fresh entry
                        n_slot     = r_used[IDX_W-1:0];
                        n_ent.key    = r_key;
                        n_ent.errors = '0;
                        n_ent.open   = 1'b0;
                        n_used     = r_used + CNT_W'(1);
                        n_state    = ST_UPDATE;
                    end else begin
                        n_status   = STS_FULL;
                        n_res_open = 1'b0;
                        n_res_cnt  = '0;
                        n_state    = ST_DONE;
                    end
                end else begin
                    n_status   = STS_UNTRACKED;
                    n_res_open = 1'b0;
                    n_res_cnt  = '0;
                    n_state    = ST_DONE;
                end
            end
            ST_UPDATE: begin
                // apply the event to the found or appended entry and write it back
                case (r_op)
                    OP_ERROR: begin
                        wr_data.errors = inc_cnt;
                        wr_data.open   = r_ent.open || (inc_cnt >= r_thr);
                    end
                    OP_SUCCESS: begin
                        wr_data.errors = '0;
                    end
                    OP_RESET_ONE: begin
                        wr_data.errors = '0;
                        wr_data.open   = 1'b0;
                    end
                    default: begin
                    end
                endcase
                wr_en      = 1'b1;
                n_status   = STS_OK;
                n_res_open = wr_data.open;
                n_res_cnt  = wr_data.errors;
                n_state    = ST_DONE;
            end
            ST_DONE: begin
                if (ld) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pend  <= 1'b0;
            r_used  <= '0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            r_used  <= n_used;
        end
    end

    // Request payload and working registers
    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_key      <= n_key;
        r_idx      <= n_idx;
        r_slot     <= n_slot;
        r_ent      <= n_ent;
        r_status   <= n_status;
        r_res_open <= n_res_open;
        r_res_cnt  <= n_res_cnt;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ld) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld) begin
            r_out_status <= r_status;
            r_out_open   <= r_res_open;
            r_out_cnt    <= r_res_cnt;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_is_open     = r_out_open;
    assign o_error_count = r_out_cnt;

    // Checks
`include "circuit_breaker_table_assert.svh"

    `CBT_ASSERT_IMPLY(a_used_bound, 1'b1, r_used <= USED_MAX, "used entries beyond table depth")
    `CBT_ASSERT_NEXT(a_busy_after_accept, i_valid && !o_stall, o_stall, "not busy after request")
    `CBT_ASSERT_NEXT(a_result_shown, ld, o_valid, "loaded result not presented")
    `CBT_ASSERT_IMPLY(a_miss_zero, o_valid && (o_status != STS_OK), !o_is_open && (o_error_count == 16'd0), "miss result not zero")

endmodule
